FILE: hw/rtl/imh_pkg.sv
package imh_pkg;

  localparam int unsigned NodeCountDef = 4096;
  localparam int unsigned KeyBitsDef   = 32;

  localparam int unsigned IdW  = 12;
  localparam int unsigned OutKeyW = 32;
  localparam int unsigned OpW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_POP    = 3'd2,
    OP_PEEK   = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_RSV5   = 3'd5,
    OP_RSV6   = 3'd6,
    OP_RSV7   = 3'd7
  } op_e;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    DC_NONE,       // nothing
    DC_LATCH,      // capture the request and read the position map
    DC_RD_TOP,     // read heap slot 1 and the last slot
    DC_RD_LAST,    // read the last slot
    DC_RD_PARENT,  // read the parent of the hole
    DC_RD_KIDS,    // read both children of the hole
    DC_MOVE_UP,    // move parent into hole, hole goes up
    DC_MOVE_DOWN,  // move chosen child into hole, hole goes down
    DC_PLACE,      // write the moving entry at the hole
    DC_CLR_MAP,    // clear position map entry of the node read at the sweep index
    DC_RD_SWEEP,   // read heap slot at the sweep index
    DC_FINISH,     // raise done, drive result
    DC_INIT_CLR    // zero the position map entry at the sweep index after reset
  } dcmd_e;

  typedef struct packed {
    dcmd_e cmd;
    logic  set_hole_pos;   // hole := position of the request node
    logic  set_hole_last;  // hole := old count + 1 (append)
    logic  set_hole_one;   // hole := 1
    logic  mov_from_req;   // moving entry := request
    logic  mov_from_last;  // moving entry := last slot
    logic  cnt_inc;
    logic  cnt_dec;
    logic  cnt_clr;
    logic  unmap_req;      // clear map of request node
    logic  unmap_top;      // clear map of top node
    logic  res_top;        // result carries the top entry
  } ctl_t;

  typedef struct packed {
    logic id_ok;
    logic present;         // request node is in the heap
    logic empty;
    logic pos_is_last;
    logic hole_gt1;
    logic parent_less;     // mov key < parent key  (up move)
    logic parent_gt;       // parent key > mov key  (either choice)
    logic has_child;
    logic child_less;      // chosen child key < mov key
    logic cnt_full;
    logic cnt_zero;
    logic cnt_one;
    logic sweep_done;
    logic init_last;       // last position map entry is being zeroed
  } sts_t;

endpackage

FILE: hw/rtl/imh_datapath.sv
module imh_datapath import imh_pkg::*; #(
  parameter int unsigned NodeCount = NodeCountDef,
  parameter int unsigned KeyBits   = KeyBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ctl_t                            ctl_i,
  input  logic [IdW-1:0]                  node_id_i,
  input  logic [OutKeyW-1:0]              node_key_i,
  output sts_t                            sts_o,
  output logic                            done_o,
  output logic                            valid_res_o,
  output logic [IdW-1:0]                  out_node_id_o,
  output logic [OutKeyW-1:0]              out_key_o,
  output logic [$clog2(NodeCount+1)-1:0]  entry_count_o
);

  localparam int unsigned PosW = $clog2(NodeCount + 1);
  localparam int unsigned AdrW = $clog2(NodeCount);
  localparam int unsigned NidW = ((AdrW > IdW) ? AdrW : IdW) + 1;

  // Heap slots 1..NodeCount are stored at address pos-1.
  logic [AdrW-1:0]    heap_id  [NodeCount];
  logic [KeyBits-1:0] heap_key [NodeCount];
  logic [PosW-1:0]    pmap     [NodeCount];

  logic [IdW-1:0]     rid_q;
  logic [KeyBits-1:0] rkey_q;
  logic [PosW-1:0]    cnt_q, hole_q, sweep_q;
  logic [AdrW-1:0]    mid_q;
  logic [KeyBits-1:0] mkey_q;
  logic [AdrW-1:0]    a_id_q, b_id_q;
  logic [KeyBits-1:0] a_key_q, b_key_q;
  logic [PosW-1:0]    pos_q;
  logic               id_ok_q;

  logic               res_v_q;
  logic [IdW-1:0]     res_id_q;
  logic [OutKeyW-1:0] res_key_q;
  logic               done_q;

  logic [NidW-1:0]    id_ext;
  logic [AdrW-1:0]    rid_a;
  logic [PosW-1:0]    left_pos, right_pos;
  logic               pick_right;
  logic [AdrW-1:0]    ch_id;
  logic [KeyBits-1:0] ch_key;
  logic [PosW-1:0]    ch_pos;
  logic [PosW-1:0]    rd_pos_a, rd_pos_b;
  logic               rd_en;

  assign id_ext = NidW'(node_id_i);
  assign rid_a  = AdrW'(rid_q);

  assign left_pos   = PosW'({hole_q, 1'b0});
  assign right_pos  = left_pos + PosW'(1);
  assign pick_right = (left_pos != cnt_q) && (b_key_q < a_key_q);
  assign ch_id      = pick_right ? b_id_q : a_id_q;
  assign ch_key     = pick_right ? b_key_q : a_key_q;
  assign ch_pos     = pick_right ? right_pos : left_pos;

  always_comb begin
    rd_pos_a = PosW'(1);
    rd_pos_b = cnt_q;
    rd_en    = 1'b1;
    unique case (ctl_i.cmd)
      DC_RD_TOP:    begin rd_pos_a = PosW'(1); rd_pos_b = cnt_q; end
      DC_RD_LAST:   begin rd_pos_a = cnt_q;    rd_pos_b = cnt_q; end
      DC_RD_PARENT: begin rd_pos_a = hole_q >> 1; rd_pos_b = hole_q >> 1; end
      DC_RD_KIDS:   begin rd_pos_a = left_pos; rd_pos_b = right_pos; end
      DC_RD_SWEEP:  begin rd_pos_a = sweep_q;  rd_pos_b = sweep_q; end
      default:      rd_en = 1'b0;
    endcase
  end

  // Heap memory: two registered read ports, one write port.
  logic               wr_en;
  logic [PosW-1:0]    wr_pos;
  logic [AdrW-1:0]    wr_id;
  logic [KeyBits-1:0] wr_key;

  always_comb begin
    wr_en  = 1'b0;
    wr_pos = hole_q;
    wr_id  = mid_q;
    wr_key = mkey_q;
    unique case (ctl_i.cmd)
      DC_MOVE_UP:   begin wr_en = 1'b1; wr_id = a_id_q; wr_key = a_key_q; end
      DC_MOVE_DOWN: begin wr_en = 1'b1; wr_id = ch_id;  wr_key = ch_key;  end
      DC_PLACE:     wr_en = 1'b1;
      default:      wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_id[AdrW'(wr_pos - PosW'(1))]  <= wr_id;
      heap_key[AdrW'(wr_pos - PosW'(1))] <= wr_key;
    end
    if (rd_en) begin
      a_id_q  <= heap_id[AdrW'(rd_pos_a - PosW'(1))];
      a_key_q <= heap_key[AdrW'(rd_pos_a - PosW'(1))];
      b_id_q  <= heap_id[AdrW'(rd_pos_b - PosW'(1))];
      b_key_q <= heap_key[AdrW'(rd_pos_b - PosW'(1))];
    end
  end

  // Position map memory: one write port, one registered read. After reset
  // a pass over every node writes zero, so an absent node reads position 0.
  logic              pm_wr;
  logic [AdrW-1:0]   pm_wa;
  logic [PosW-1:0]   pm_wd;

  always_comb begin
    pm_wr = wr_en;
    pm_wa = wr_id;
    pm_wd = wr_pos;
    if (ctl_i.cmd == DC_INIT_CLR) begin
      pm_wr = 1'b1;
      pm_wa = AdrW'(sweep_q);
      pm_wd = '0;
    end else if (ctl_i.cmd == DC_CLR_MAP) begin
      pm_wr = 1'b1;
      pm_wa = a_id_q;
      pm_wd = '0;
    end else if (ctl_i.unmap_req) begin
      pm_wr = 1'b1;
      pm_wa = rid_a;
      pm_wd = '0;
    end else if (ctl_i.unmap_top) begin
      pm_wr = 1'b1;
      pm_wa = AdrW'(res_id_q);
      pm_wd = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pm_wr) begin
      pmap[pm_wa] <= pm_wd;
    end
    if (ctl_i.cmd == DC_LATCH) begin
      pos_q <= pmap[AdrW'(node_id_i)];
    end
  end

  // Control and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      done_q  <= 1'b0;
      res_v_q <= 1'b0;
      id_ok_q <= 1'b0;
      hole_q  <= '0;
      sweep_q <= '0;
    end else begin
      done_q <= (ctl_i.cmd == DC_FINISH);
      if (ctl_i.cmd == DC_LATCH) begin
        id_ok_q <= (id_ext < NidW'(NodeCount));
        sweep_q <= PosW'(1);
        res_v_q <= 1'b0;
      end
      if (ctl_i.cnt_inc) cnt_q <= cnt_q + PosW'(1);
      if (ctl_i.cnt_dec) cnt_q <= cnt_q - PosW'(1);
      if (ctl_i.cnt_clr) cnt_q <= '0;
      if (ctl_i.set_hole_pos)  hole_q <= pos_q;
      if (ctl_i.set_hole_last) hole_q <= cnt_q + PosW'(1);
      if (ctl_i.set_hole_one)  hole_q <= PosW'(1);
      if (ctl_i.cmd == DC_MOVE_UP)   hole_q <= hole_q >> 1;
      if (ctl_i.cmd == DC_MOVE_DOWN) hole_q <= ch_pos;
      if (ctl_i.cmd == DC_CLR_MAP || ctl_i.cmd == DC_INIT_CLR) begin
        sweep_q <= sweep_q + PosW'(1);
      end
      if (ctl_i.res_top) res_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == DC_LATCH) begin
      rid_q     <= node_id_i;
      rkey_q    <= KeyBits'(node_key_i);
      res_id_q  <= '0;
      res_key_q <= '0;
    end
    if (ctl_i.mov_from_req) begin
      mid_q  <= rid_a;
      mkey_q <= rkey_q;
    end
    if (ctl_i.mov_from_last) begin
      mid_q  <= b_id_q;
      mkey_q <= b_key_q;
    end
    if (ctl_i.res_top) begin
      res_id_q  <= IdW'(a_id_q);
      res_key_q <= OutKeyW'(a_key_q);
    end
  end

  assign sts_o.id_ok       = id_ok_q;
  assign sts_o.present     = (pos_q != '0) && (pos_q <= cnt_q);
  assign sts_o.empty       = (cnt_q == '0);
  assign sts_o.pos_is_last = (pos_q == cnt_q);
  assign sts_o.hole_gt1    = (hole_q > PosW'(1));
  assign sts_o.parent_less = (mkey_q < a_key_q);
  assign sts_o.parent_gt   = (a_key_q > mkey_q);
  assign sts_o.has_child   = ({hole_q, 1'b0} <= {1'b0, cnt_q});
  assign sts_o.child_less  = (ch_key < mkey_q);
  assign sts_o.cnt_full    = (cnt_q == PosW'(NodeCount));
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.cnt_one     = (cnt_q == PosW'(1));
  assign sts_o.sweep_done  = (sweep_q > cnt_q);
  assign sts_o.init_last   = (sweep_q == PosW'(NodeCount - 1));

  assign done_o        = done_q;
  assign valid_res_o   = done_q & res_v_q;
  assign out_node_id_o = done_q ? res_id_q : '0;
  assign out_key_o     = done_q ? res_key_q : '0;
  assign entry_count_o = cnt_q;

  hole_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.cmd == DC_PLACE) |-> (hole_q != '0) && (hole_q <= cnt_q))
    else $error("placement outside the heap");
  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PosW'(NodeCount))
    else $error("entry count overflow");
  res_once_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

endmodule

FILE: hw/rtl/imh_ctrl.sv
module imh_ctrl import imh_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [OpW-1:0] opcode_i,
  input  sts_t           sts_i,
  output logic           busy_o,
  output ctl_t           ctl_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_TOPWAIT = 4'd2;
  localparam logic [3:0] S_LASTW   = 4'd3;
  localparam logic [3:0] S_EITHER  = 4'd4;
  localparam logic [3:0] S_UPCMP   = 4'd5;
  localparam logic [3:0] S_DNTEST  = 4'd6;
  localparam logic [3:0] S_DNCMP   = 4'd7;
  localparam logic [3:0] S_SWRD    = 4'd8;
  localparam logic [3:0] S_SWCLR   = 4'd9;
  localparam logic [3:0] S_FINISH  = 4'd10;
  localparam logic [3:0] S_UPTEST  = 4'd11;
  localparam logic [3:0] S_PLACE   = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;
  localparam logic [3:0] S_INIT    = 4'd14;

  logic [3:0]     state_q, state_d;
  logic [OpW-1:0] op_q;
  logic           unmap_q, unmap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q    <= OP_RSV7;
      unmap_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unmap_q <= unmap_d;
      if (start_i && state_q == S_IDLE) op_q <= opcode_i;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    unmap_d = unmap_q;
    ctl_o   = '0;
    ctl_o.cmd = DC_NONE;
    unique case (state_q)
      S_INIT: begin
        // Zero the position map, one node per cycle.
        ctl_o.cmd = DC_INIT_CLR;
        if (sts_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.cmd = DC_LATCH;
          unmap_d = 1'b0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl_o.mov_from_req = 1'b1;
        state_d = S_FINISH;
        unique case (op_e'(op_q))
          OP_INSERT: begin
            if (sts_i.id_ok) begin
              if (!sts_i.present) begin
                if (!sts_i.cnt_full) begin
                  ctl_o.set_hole_last = 1'b1;
                  ctl_o.cnt_inc = 1'b1;
                  state_d = S_UPTEST;
                end
              end else begin
                ctl_o.set_hole_pos = 1'b1;
                state_d = S_EITHER;
                ctl_o.cmd = DC_NONE;
              end
            end
          end
          OP_DELETE: begin
            if (sts_i.id_ok && sts_i.present) begin
              unmap_d = 1'b1;
              if (sts_i.pos_is_last) begin
                ctl_o.cnt_dec = 1'b1;
              end else begin
                ctl_o.set_hole_pos = 1'b1;
                ctl_o.cmd = DC_RD_LAST;
                state_d = S_LASTW;
              end
            end
          end
          OP_POP, OP_PEEK: begin
            if (!sts_i.empty) begin
              ctl_o.cmd = DC_RD_TOP;
              state_d = S_TOPWAIT;
            end
          end
          OP_CLEAR: begin
            state_d = S_SWRD;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_TOPWAIT: begin
        ctl_o.res_top = 1'b1;
        if (op_e'(op_q) == OP_POP) begin
          ctl_o.unmap_top = 1'b0;
          ctl_o.mov_from_last = 1'b1;
          ctl_o.set_hole_one = 1'b1;
          ctl_o.cnt_dec = 1'b1;
          unmap_d = 1'b1;
          state_d = sts_i.cnt_one ? S_DONE : S_DNTEST;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_LASTW: begin
        // The last entry moves into the hole left by the deleted node.
        ctl_o.mov_from_last = 1'b1;
        ctl_o.cnt_dec = 1'b1;
        ctl_o.unmap_req = 1'b1;
        unmap_d = 1'b0;
        state_d = S_EITHER;
      end
      S_EITHER: begin
        if (sts_i.hole_gt1) begin
          ctl_o.cmd = DC_RD_PARENT;
          state_d = S_UPCMP;
        end else begin
          state_d = S_DNTEST;
        end
      end
      S_UPTEST: begin
        if (sts_i.hole_gt1) begin
          ctl_o.cmd = DC_RD_PARENT;
          state_d = S_UPCMP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_UPCMP: begin
        if (sts_i.parent_less) begin
          ctl_o.cmd = DC_MOVE_UP;
          state_d = S_UPTEST;
        end else begin
          state_d = S_DNTEST;
        end
      end
      S_DNTEST: begin
        if (sts_i.has_child) begin
          ctl_o.cmd = DC_RD_KIDS;
          state_d = S_DNCMP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DNCMP: begin
        if (sts_i.child_less) begin
          ctl_o.cmd = DC_MOVE_DOWN;
          state_d = S_DNTEST;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        ctl_o.cmd = DC_PLACE;
        state_d = S_DONE;
      end
      S_DONE: begin
        // Removal of the top node's map entry happens after any sift wrote it.
        if (unmap_q && op_e'(op_q) == OP_POP) ctl_o.unmap_top = 1'b1;
        if (unmap_q && op_e'(op_q) == OP_DELETE) ctl_o.unmap_req = 1'b1;
        unmap_d = 1'b0;
        state_d = S_FINISH;
      end
      S_SWRD: begin
        if (sts_i.sweep_done) begin
          ctl_o.cnt_clr = 1'b1;
          state_d = S_FINISH;
        end else begin
          ctl_o.cmd = DC_RD_SWEEP;
          state_d = S_SWCLR;
        end
      end
      S_SWCLR: begin
        ctl_o.cmd = DC_CLR_MAP;
        state_d = S_SWRD;
      end
      S_FINISH: begin
        if (unmap_q) begin
          ctl_o.unmap_req = 1'b1;
          unmap_d = 1'b0;
        end else begin
          ctl_o.cmd = DC_FINISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  idle_on_start_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not make the unit busy");
  finish_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.cmd == DC_FINISH) |=> !busy_o)
    else $error("unit stayed busy after finishing");
  single_cnt_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ctl_o.cnt_inc, ctl_o.cnt_dec, ctl_o.cnt_clr}) <= 1)
    else $error("conflicting count updates");

endmodule

FILE: hw/rtl/indexed_min_heap_unsigned_key_unit.sv
// Indexed binary min-heap of node identifiers keyed by unsigned cost. Pulse
// start_i while busy_o is low to hand in one item: insert or re-key, delete
// by identifier, pop, peek or clear. Exactly one result comes back per item,
// on the cycle that done_o is high; the receiver cannot stall it, so it must
// capture the result ports in that cycle. entry_count_o is the number of
// entries after the operation. An item is decoded and then may run a sift;
// each heap level walked by the sift first issues the registered read of
// the heap memory and then compares and writes. Clear sweeps the live
// entries, reading each slot and then zeroing the position-map entry of
// its node. After reset the unit stays busy while it writes zero into all
// NodeCount position-map entries (4096 by default).
module indexed_min_heap_unsigned_key_unit import imh_pkg::*; #(
  parameter int unsigned NodeCount = NodeCountDef,
  parameter int unsigned KeyBits   = KeyBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [OpW-1:0]                  opcode_i,
  input  logic [IdW-1:0]                  node_id_i,
  input  logic [OutKeyW-1:0]              node_key_i,
  output logic                            done_o,
  output logic                            valid_res_o,
  output logic [IdW-1:0]                  out_node_id_o,
  output logic [OutKeyW-1:0]              out_key_o,
  output logic [$clog2(NodeCount+1)-1:0]  entry_count_o
);

  ctl_t ctl;
  sts_t sts;

  imh_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .busy_o   (busy_o),
    .ctl_o    (ctl)
  );

  imh_datapath #(
    .NodeCount (NodeCount),
    .KeyBits   (KeyBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .node_id_i     (node_id_i),
    .node_key_i    (node_key_i),
    .sts_o         (sts),
    .done_o        (done_o),
    .valid_res_o   (valid_res_o),
    .out_node_id_o (out_node_id_o),
    .out_key_o     (out_key_o),
    .entry_count_o (entry_count_o)
  );

endmodule
